/* src/srrip_pkg.sv */
`default_nettype none
package srrip_pkg;

	// Input action codes.
	localparam logic [1:0] ACT_VICTIM = 2'd0;
	localparam logic [1:0] ACT_FILL   = 2'd1;
	localparam logic [1:0] ACT_UPDATE = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_REUSE  = 1'b0;
	localparam logic CFG_STREAM = 1'b1;

	localparam int SIG_W = 16;

	// One input item as carried by the input channel.
	typedef struct packed {
		logic [1:0]  action;
		logic [10:0] set_index;
		logic [3:0]  way_index;
		logic [15:0] valid_mask;
		logic [63:0] pc;
		logic        is_write;
		logic        was_hit;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [3:0] victim_way;
		logic       chose_invalid;
	} rsp_t;

	// Fold a PC into a 16-bit signature by XOR of its four quarters.
	function automatic logic [SIG_W-1:0] fold_pc(input logic [63:0] pc);
		fold_pc = pc[15:0] ^ pc[31:16] ^ pc[47:32] ^ pc[63:48];
	endfunction

endpackage
`default_nettype wire

/* src/srrip_if.sv */
`default_nettype none
interface srrip_req_if;
	logic               valid;
	logic               ready;
	srrip_pkg::req_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface srrip_rsp_if;
	logic               valid;
	logic               ready;
	srrip_pkg::rsp_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/srrip_ram.sv */
`default_nettype none
module srrip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* src/srrip_front.sv */
`default_nettype none
module srrip_front #(
	parameter int WAY_COUNT = 16,
	parameter int QDEPTH    = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	srrip_req_if.sink               req,
	// Queue head toward the back end.
	output logic                    q_valid,
	output srrip_pkg::req_t         q_data,
	output logic                    q_inv,
	output logic [3:0]              q_inv_way,
	input  wire logic               q_pop
);
	localparam int QW = $clog2(QDEPTH);

	typedef struct packed {
		srrip_pkg::req_t req;
		logic            inv;
		logic [3:0]      inv_way;
	} qent_t;

	qent_t         ent_q [QDEPTH];
	logic [QW-1:0] rd_q, wr_q;
	logic [QW:0]   cnt_q;
	qent_t         new_ent;
	logic          push;

	// Classify: find the lowest invalid way; ways beyond 16 read as invalid.
	always_comb begin
		new_ent.req     = req.data;
		new_ent.inv     = 1'b0;
		new_ent.inv_way = '0;
		for (int w = WAY_COUNT - 1; w >= 0; w--) begin
			if (w >= 16 || !req.data.valid_mask[w[3:0]]) begin
				new_ent.inv     = 1'b1;
				new_ent.inv_way = w[3:0];
			end
		end
	end

	assign req.ready = (cnt_q != QDEPTH[QW:0]);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != '0);
	assign q_data    = ent_q[rd_q].req;
	assign q_inv     = ent_q[rd_q].inv;
	assign q_inv_way = ent_q[rd_q].inv_way;

	// Queue payload.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= new_ent;
		end
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= (rd_q == QW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(q_pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QDEPTH) else $error("queue overflow");
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == QDEPTH && !q_pop) |=> !req.ready) else $error("ready while full");
`endif
endmodule
`default_nettype wire

/* src/srrip_back.sv */
`default_nettype none
module srrip_back #(
	parameter int SET_COUNT       = 2048,
	parameter int WAY_COUNT       = 16,
	parameter int COUNTER_ENTRIES = 16384,
	parameter int COUNTER_MAX     = 7,
	parameter int RRPV_MAX        = 3,
	parameter int THROTTLE_PERIOD = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire srrip_pkg::req_t    q_data,
	input  wire logic               q_inv,
	input  wire logic [3:0]         q_inv_way,
	output logic                    q_pop,
	input  wire logic [2:0]         reuse_thr,
	input  wire logic [2:0]         stream_thr,
	srrip_rsp_if.source             rsp
);
	localparam int SETW  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int WAYW  = $clog2(WAY_COUNT);
	localparam int RW    = $clog2(RRPV_MAX + 1);
	localparam int CW    = $clog2(COUNTER_MAX + 1);
	localparam int SLW   = $clog2(COUNTER_ENTRIES);
	localparam int TW    = $clog2(THROTTLE_PERIOD);
	localparam int ROWW  = WAY_COUNT * (RW + SLW + 1);
	localparam int CLRW  = (SETW > SLW) ? SETW : SLW;
	localparam int CLRN  = (SET_COUNT > COUNTER_ENTRIES) ? SET_COUNT : COUNTER_ENTRIES;

	// Sequencer states.
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ROW   = 3'd2;
	localparam logic [2:0] ST_CRD   = 3'd3;
	localparam logic [2:0] ST_CWB   = 3'd4;

	typedef struct packed {
		logic [RW-1:0]  rrpv;
		logic [SLW-1:0] slot;
		logic           reused;
	} line_t;

	logic [2:0]       st_q;
	logic [CLRW:0]    clr_q;
	srrip_pkg::req_t  cur_q;
	logic             inv_q;
	logic [3:0]       inv_way_q;
	line_t [WAY_COUNT-1:0] row_q;
	logic             cdec_q, cinc_q;
	logic [SLW-1:0]   slot_q;
	logic [TW-1:0]    thr_q;
	logic [WAYW-1:0]  victim_q;

	// Set row RAM: one row per set holds all ways.
	logic             row_we;
	logic [SETW-1:0]  row_waddr, row_raddr;
	logic [ROWW-1:0]  row_wdata, row_rdata;
	line_t [WAY_COUNT-1:0] row_rd, row_new;

	// Counter RAM.
	logic             ctr_we;
	logic [SLW-1:0]   ctr_waddr, ctr_raddr;
	logic [CW-1:0]    ctr_wdata, ctr_rdata;

	srrip_ram #(.WIDTH(ROWW), .DEPTH(SET_COUNT)) u_rows (
		.clk, .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
		.raddr(row_raddr), .rdata(row_rdata));
	srrip_ram #(.WIDTH(CW), .DEPTH(COUNTER_ENTRIES)) u_ctrs (
		.clk, .we(ctr_we), .waddr(ctr_waddr), .wdata(ctr_wdata),
		.raddr(ctr_raddr), .rdata(ctr_rdata));

	assign row_rd = row_rdata;

	logic set_ok, way_ok, is_victim, takes;
	logic [SLW-1:0] fill_slot;
	always_comb begin
		set_ok    = ({16'd0, q_data.set_index} < 27'(SET_COUNT));
		way_ok    = ({1'b0, q_data.way_index} < 5'(WAY_COUNT));
		is_victim = (q_data.action == srrip_pkg::ACT_VICTIM);
		fill_slot = SLW'(srrip_pkg::fold_pc(q_data.pc));
	end

	// Pop whenever idle with room on the output (result register free).
	assign takes = (st_q == ST_IDLE) && q_valid && !rsp.valid;
	assign q_pop = takes;

	// Aging and victim selection over the row read out of the RAM.
	logic [RW-1:0]   maxv;
	logic [WAYW-1:0] vic;
	line_t [WAY_COUNT-1:0] aged;
	always_comb begin
		maxv = '0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (row_rd[w].rrpv > maxv) maxv = row_rd[w].rrpv;
		end
		if (maxv > RW'(RRPV_MAX)) maxv = RW'(RRPV_MAX);
		aged = row_rd;
		for (int w = 0; w < WAY_COUNT; w++) begin
			logic [RW:0] v;
			v = {1'b0, row_rd[w].rrpv} + {1'b0, RW'(RRPV_MAX) - maxv};
			aged[w].rrpv = (v > (RW+1)'(RRPV_MAX)) ? RW'(RRPV_MAX) : v[RW-1:0];
		end
		vic = '0;
		for (int w = WAY_COUNT - 1; w >= 0; w--) begin
			if (aged[w].rrpv == RW'(RRPV_MAX)) vic = w[WAYW-1:0];
		end
	end

	// Fill insertion value; thresholds are compared at full width.
	logic [RW-1:0] ins_rrpv;
	logic          adv_thr;
	always_comb begin
		adv_thr  = 1'b0;
		if (cur_q.is_write) begin
			ins_rrpv = RW'(RRPV_MAX);
		end else if ({3'd0, ctr_rdata} >= {{CW{1'b0}}, reuse_thr}) begin
			ins_rrpv = RW'(RRPV_MAX - 2);
		end else if ({3'd0, ctr_rdata} <= {{CW{1'b0}}, stream_thr}) begin
			ins_rrpv = (thr_q == '0) ? RW'(RRPV_MAX - 1) : RW'(RRPV_MAX);
			adv_thr  = 1'b1;
		end else begin
			ins_rrpv = RW'(RRPV_MAX - 1);
		end
	end

	// Row update for the current item.
	logic [WAYW-1:0] cway;
	always_comb begin
		cway    = WAYW'(cur_q.way_index);
		row_new = row_q;
		if (cur_q.action == srrip_pkg::ACT_FILL) begin
			row_new[cway].rrpv   = ins_rrpv;
			row_new[cway].slot   = SLW'(srrip_pkg::fold_pc(cur_q.pc));
			row_new[cway].reused = 1'b0;
		end else if (cur_q.action == srrip_pkg::ACT_UPDATE) begin
			row_new[cway].rrpv   = '0;
			row_new[cway].reused = 1'b1;
		end
	end

	// RAM port control.
	always_comb begin
		row_raddr = q_data.set_index[SETW-1:0];
		ctr_raddr = fill_slot;
		row_we    = 1'b0;
		row_waddr = cur_q.set_index[SETW-1:0];
		row_wdata = row_new;
		ctr_we    = 1'b0;
		ctr_waddr = slot_q;
		ctr_wdata = ctr_rdata;
		case (st_q)
			ST_CLEAR: begin
				row_we    = ({1'b0, clr_q} < (CLRW+1)'(SET_COUNT));
				row_waddr = clr_q[SETW-1:0];
				for (int w = 0; w < WAY_COUNT; w++) begin
					row_wdata[w*(RW+SLW+1) +: RW+SLW+1] = {RW'(RRPV_MAX), SLW'(0), 1'b0};
				end
				ctr_we    = ({1'b0, clr_q} < (CLRW+1)'(COUNTER_ENTRIES));
				ctr_waddr = clr_q[SLW-1:0];
				ctr_wdata = CW'(COUNTER_MAX / 2);
			end
			ST_CWB: begin
				row_we = (cur_q.action != srrip_pkg::ACT_VICTIM);
				if (cdec_q) begin
					ctr_we    = (ctr_rdata != '0);
					ctr_wdata = ctr_rdata - 1'b1;
				end else if (cinc_q) begin
					ctr_we    = (ctr_rdata != CW'(COUNTER_MAX));
					ctr_wdata = ctr_rdata + 1'b1;
				end
			end
			ST_CRD: begin
				ctr_raddr = slot_q;
				if (cur_q.action == srrip_pkg::ACT_VICTIM) begin
					row_we    = 1'b1;
					row_wdata = row_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer: clear pass, then read row, read counter, write back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			clr_q     <= '0;
			thr_q     <= '0;
			rsp.valid <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (CLRW+1)'(CLRN - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (takes) begin
						if (is_victim && q_inv) begin
							rsp.valid <= 1'b1;
						end else if (is_victim && !set_ok) begin
							rsp.valid <= 1'b1;
						end else if (is_victim || (set_ok && way_ok &&
								(q_data.action == srrip_pkg::ACT_FILL ||
								(q_data.action == srrip_pkg::ACT_UPDATE &&
								q_data.was_hit && !q_data.is_write)))) begin
							st_q <= ST_ROW;
						end
					end
				end
				ST_ROW: st_q <= ST_CRD;
				ST_CRD: st_q <= ST_CWB;
				ST_CWB: begin
					if (cur_q.action == srrip_pkg::ACT_FILL && adv_thr) begin
						thr_q <= (thr_q == TW'(THROTTLE_PERIOD - 1)) ? '0 : thr_q + 1'b1;
					end
					if (cur_q.action == srrip_pkg::ACT_VICTIM) rsp.valid <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Item payload and row capture.
	always_ff @(posedge clk) begin
		if (takes) begin
			cur_q     <= q_data;
			inv_q     <= q_inv;
			inv_way_q <= q_inv_way;
			slot_q    <= fill_slot;
			cdec_q    <= 1'b0;
			cinc_q    <= 1'b0;
			victim_q  <= '0;
		end
		if (st_q == ST_ROW) begin
			if (cur_q.action == srrip_pkg::ACT_VICTIM) begin
				row_q    <= aged;
				victim_q <= vic;
				slot_q   <= aged[vic].slot;
				cdec_q   <= !aged[vic].reused;
			end else begin
				row_q <= row_rd;
				if (cur_q.action == srrip_pkg::ACT_UPDATE) begin
					slot_q <= row_rd[cway].slot;
					cinc_q <= !row_rd[cway].reused;
				end
			end
		end
	end

	// Result register.
	always_comb begin
		rsp.data.chose_invalid = inv_q;
		rsp.data.victim_way    = inv_q ? inv_way_q : 4'(victim_q);
	end

`ifndef ASSERT_OFF
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (st_q == ST_IDLE)) else $error("pop while busy");
	a_victim_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CWB && cur_q.action == srrip_pkg::ACT_VICTIM) |=> rsp.valid)
		else $error("victim result missing");
	a_no_rsp_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CWB && cur_q.action != srrip_pkg::ACT_VICTIM && !rsp.valid)
		|=> !rsp.valid) else $error("spurious result");
`endif
endmodule
`default_nettype wire

/* src/ship_rrip_cache_replacement.sv */
`default_nettype none
// Channel  Role    Payload
// req      sink    action, set_index, way_index, valid_mask, pc, is_write, was_hit
// rsp      source  victim_way, chose_invalid (victim requests only)
// cfg      write   cfg_we, cfg_index, cfg_data
// An item is held in the two-entry front queue until the back end takes it.
// In the back end a victim request with an invalid way or an out-of-range set, and an
// item that changes no state, finish when taken; other items pass through take, row
// read, counter read and write back, as both RAMs have a registered read port.
// After reset a clearing pass initializes every set row and counter entry before
// items are processed; the front queue still accepts up to two items meanwhile.
// The back end waits while a result is held in the output register.
module ship_rrip_cache_replacement #(
	parameter int SET_COUNT       = 2048,
	parameter int WAY_COUNT       = 16,
	parameter int COUNTER_ENTRIES = 16384,
	parameter int COUNTER_MAX     = 7,
	parameter int RRPV_MAX        = 3,
	parameter int THROTTLE_PERIOD = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	srrip_req_if.sink       req,
	srrip_rsp_if.source     rsp,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [2:0] cfg_data
);
	logic [2:0]      reuse_thr_q, stream_thr_q;
	logic            q_valid, q_inv, q_pop;
	srrip_pkg::req_t q_data;
	logic [3:0]      q_inv_way;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reuse_thr_q  <= 3'd5;
			stream_thr_q <= 3'd2;
		end else if (cfg_we) begin
			if (cfg_index == srrip_pkg::CFG_REUSE) reuse_thr_q <= cfg_data;
			if (cfg_index == srrip_pkg::CFG_STREAM) stream_thr_q <= cfg_data;
		end
	end

	srrip_front #(.WAY_COUNT(WAY_COUNT), .QDEPTH(2)) u_front (
		.clk, .arst_n, .req, .q_valid, .q_data, .q_inv, .q_inv_way, .q_pop);

	srrip_back #(
		.SET_COUNT(SET_COUNT), .WAY_COUNT(WAY_COUNT), .COUNTER_ENTRIES(COUNTER_ENTRIES),
		.COUNTER_MAX(COUNTER_MAX), .RRPV_MAX(RRPV_MAX),
		.THROTTLE_PERIOD(THROTTLE_PERIOD)
	) u_back (
		.clk, .arst_n, .q_valid, .q_data, .q_inv, .q_inv_way, .q_pop,
		.reuse_thr(reuse_thr_q), .stream_thr(stream_thr_q), .rsp);
endmodule
`default_nettype wire

/* test/testbench.sv */
`default_nettype none
module testbench;

	localparam int SETS = 2048;
	localparam int WAYS = 16;
	localparam int CTR_ENTRIES = 16384;
	localparam int CTR_MAX = 7;
	localparam int RRPV_TOP = 3;
	localparam int THROTTLE_LEN = 32;
	localparam int STALL_LIMIT = 60000;
	localparam int SETTLE_CYCLES = 24;
	localparam int PHASE_ITEMS = 175;

	// Mirror of the replacement state; predicts the victim answer for each request.
	class replacement_scoreboard;
		logic [1:0]  rrpv[SETS*WAYS];
		logic [15:0] sig_store[SETS*WAYS];
		bit          line_reused[SETS*WAYS];
		logic [2:0]  reuse_ctr[CTR_ENTRIES];
		int unsigned throttle;
		int unsigned reuse_thr;
		int unsigned stream_thr;
		srrip_pkg::rsp_t pending_victims[$];
		int          errors;

		function new();
			foreach (rrpv[i]) begin
				rrpv[i] = 2'(RRPV_TOP);
				sig_store[i] = '0;
				line_reused[i] = 0;
			end
			foreach (reuse_ctr[i]) reuse_ctr[i] = 3'(CTR_MAX / 2);
			throttle = 0;
			reuse_thr = 5;
			stream_thr = 2;
			errors = 0;
		endfunction

		function void write_reg(logic index, logic [2:0] value);
			if (index == srrip_pkg::CFG_REUSE)
				reuse_thr = value;
			else
				stream_thr = value;
		endfunction

		// Apply one accepted item to the mirror state.
		function void note_item(srrip_pkg::req_t it);
			int unsigned base, idx, maxv, victim, slot, c;
			logic [15:0] s;
			srrip_pkg::rsp_t r;
			base = it.set_index * WAYS;
			idx = base + it.way_index;
			if (it.action == srrip_pkg::ACT_VICTIM) begin
				for (int w = 0; w < WAYS; w++) begin
					if (!it.valid_mask[w]) begin
						r.victim_way = 4'(w);
						r.chose_invalid = 1'b1;
						pending_victims.push_back(r);
						return;
					end
				end
				// SRRIP aging: raise the whole set until some way is distant.
				maxv = 0;
				for (int w = 0; w < WAYS; w++)
					if (rrpv[base+w] > maxv) maxv = rrpv[base+w];
				for (int w = 0; w < WAYS; w++)
					rrpv[base+w] = 2'(rrpv[base+w] + (RRPV_TOP - maxv));
				victim = 0;
				for (int w = WAYS - 1; w >= 0; w--)
					if (rrpv[base+w] == RRPV_TOP) victim = w;
				if (!line_reused[base+victim]) begin
					slot = sig_store[base+victim] % CTR_ENTRIES;
					if (reuse_ctr[slot] > 0) reuse_ctr[slot]--;
				end
				r.victim_way = 4'(victim);
				r.chose_invalid = 1'b0;
				pending_victims.push_back(r);
			end else if (it.action == srrip_pkg::ACT_FILL) begin
				s = it.pc[15:0] ^ it.pc[31:16] ^ it.pc[47:32] ^ it.pc[63:48];
				if (it.is_write) begin
					rrpv[idx] = 2'(RRPV_TOP);
				end else begin
					c = reuse_ctr[s % CTR_ENTRIES];
					if (c >= reuse_thr) begin
						rrpv[idx] = 2'(RRPV_TOP - 2);
					end else if (c <= stream_thr) begin
						// Streaming lines: only one in the throttle period is kept near.
						rrpv[idx] = (throttle == 0) ? 2'(RRPV_TOP - 1) : 2'(RRPV_TOP);
						throttle = (throttle + 1) % THROTTLE_LEN;
					end else begin
						rrpv[idx] = 2'(RRPV_TOP - 1);
					end
				end
				sig_store[idx] = s;
				line_reused[idx] = 0;
			end else if (it.action == srrip_pkg::ACT_UPDATE) begin
				if (it.was_hit && !it.is_write) begin
					rrpv[idx] = 2'd0;
					if (!line_reused[idx]) begin
						slot = sig_store[idx] % CTR_ENTRIES;
						line_reused[idx] = 1;
						if (reuse_ctr[slot] < CTR_MAX) reuse_ctr[slot]++;
					end
				end
			end
		endfunction

		function void check_victim(srrip_pkg::rsp_t got);
			srrip_pkg::rsp_t want;
			if (pending_victims.size() == 0) begin
				$display("%0t: unexpected result way=%0d invalid=%0b", $time,
					got.victim_way, got.chose_invalid);
				errors++;
				return;
			end
			want = pending_victims.pop_front();
			if (got.victim_way !== want.victim_way) begin
				$display("%0t: victim_way expected %0d actual %0d", $time,
					want.victim_way, got.victim_way);
				errors++;
			end
			if (got.chose_invalid !== want.chose_invalid) begin
				$display("%0t: chose_invalid expected %0b actual %0b", $time,
					want.chose_invalid, got.chose_invalid);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [2:0] cfg_data;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles = 0;
	logic [10:0] hot_sets[8];
	logic [63:0] hot_pcs[16];
	replacement_scoreboard sb;

	srrip_req_if req_ch();
	srrip_rsp_if rsp_ch();

	ship_rrip_cache_replacement u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Note accepted items, check results, and watch for a stalled block.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) sb.note_item(req_ch.data);
			if (rsp_ch.valid && rsp_ch.ready) sb.check_victim(rsp_ch.data);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL ship_rrip_cache_replacement");
				$finish;
			end
		end
	end

	// Receiver back-pressure.
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_item(srrip_pkg::req_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		do @(posedge clk); while (!(req_ch.ready === 1'b1));
	endtask

	task automatic write_reg(logic index, logic [2:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(index, value);
	endtask

	// Wait until every victim answer has come back and the back end has settled.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.pending_victims.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic srrip_pkg::req_t base_item(logic [1:0] act, logic [10:0] set_i,
			logic [3:0] way_i);
		srrip_pkg::req_t it;
		it = '0;
		it.action = act;
		it.set_index = set_i;
		it.way_index = way_i;
		return it;
	endfunction

	// Random item: mostly hot sets and a small PC pool so lines train and get evicted.
	function automatic srrip_pkg::req_t random_item();
		srrip_pkg::req_t it;
		int pick;
		it.set_index = ($urandom_range(9) < 8) ? hot_sets[$urandom_range(7)]
			: 11'($urandom_range(SETS - 1));
		it.way_index = 4'($urandom_range(WAYS - 1));
		it.valid_mask = ($urandom_range(4) < 4) ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
		it.pc = ($urandom_range(9) < 8) ? hot_pcs[$urandom_range(15)]
			: {$urandom(), $urandom()};
		it.is_write = ($urandom_range(4) == 0);
		it.was_hit = ($urandom_range(3) != 0);
		pick = $urandom_range(99);
		if (pick < 40)
			it.action = srrip_pkg::ACT_VICTIM;
		else if (pick < 70)
			it.action = srrip_pkg::ACT_FILL;
		else if (pick < 96)
			it.action = srrip_pkg::ACT_UPDATE;
		else
			it.action = srrip_pkg::ACT_NONE;
		return it;
	endfunction

	initial begin
		srrip_pkg::req_t it;
		logic [2:0] reuse_vals[4];
		logic [2:0] stream_vals[4];
		reuse_vals = '{3'd0, 3'd7, 3'd3, 3'd7};
		stream_vals = '{3'd0, 3'd7, 3'd5, 3'd0};
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = srrip_pkg::CFG_REUSE;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (hot_sets[i]) hot_sets[i] = 11'($urandom_range(SETS - 1));
		hot_sets[0] = 11'd0;
		hot_sets[1] = 11'd2047;
		foreach (hot_pcs[i]) hot_pcs[i] = {$urandom(), $urandom()};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items: mask extremes, every action, write and miss updates.
		it = base_item(srrip_pkg::ACT_VICTIM, 11'd0, 4'd0);
		it.valid_mask = 16'h0000; send_item(it);
		it.valid_mask = 16'h7FFF; send_item(it);
		it.valid_mask = 16'hFFFF; send_item(it);
		it = base_item(srrip_pkg::ACT_FILL, 11'd0, 4'd0);
		it.pc = '0; send_item(it);
		it = base_item(srrip_pkg::ACT_FILL, 11'd2047, 4'd15);
		it.pc = '1; send_item(it);
		it.is_write = 1'b1; it.way_index = 4'd14; send_item(it);
		it = base_item(srrip_pkg::ACT_UPDATE, 11'd2047, 4'd15);
		it.was_hit = 1'b1; send_item(it);
		send_item(it);
		it.way_index = 4'd14; it.is_write = 1'b1; send_item(it);
		it.is_write = 1'b0; it.was_hit = 1'b0; send_item(it);
		it = base_item(srrip_pkg::ACT_NONE, 11'd2047, 4'd15);
		it.valid_mask = 16'h0000; it.pc = '1; it.is_write = 1'b1; it.was_hit = 1'b1;
		send_item(it);
		it = base_item(srrip_pkg::ACT_VICTIM, 11'd2047, 4'd0);
		it.valid_mask = 16'hFFFF; send_item(it);
		send_item(it);
		it.valid_mask = 16'hFFFE; send_item(it);
		it = base_item(srrip_pkg::ACT_VICTIM, 11'd0, 4'd0);
		it.valid_mask = 16'hFFFF; send_item(it);
		drain();

		// Random phases, each with its own idling pattern and threshold setting.
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(srrip_pkg::CFG_REUSE, reuse_vals[ph]);
			write_reg(srrip_pkg::CFG_STREAM, stream_vals[ph]);
			send_idle_pct = (ph == 1) ? 88 : (ph == 3) ? 37 : 0;
			recv_stall_pct = (ph == 2) ? 88 : (ph == 3) ? 37 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
			drain();
		end

		if (sb.errors == 0)
			$display("PASS ship_rrip_cache_replacement");
		else
			$display("FAIL ship_rrip_cache_replacement");
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
src/srrip_pkg.sv
src/srrip_if.sv
src/srrip_ram.sv
src/srrip_front.sv
src/srrip_back.sv
src/ship_rrip_cache_replacement.sv
test/testbench.sv
